/* rtl/sjsc_pkg.sv */
// ----------------------------------------------------------------------------
// Stepper jog speed controller package
// Shared widths, register codes, reset values and payload types.
// ----------------------------------------------------------------------------
package sjsc_pkg;

	// Width of the signed speed; the ramp sum width below follows in part from it.
	localparam int SPEED_BITS = 12;
	// Largest positive value the signed speed word can hold.
	localparam int SPEED_CAP = (2 ** (SPEED_BITS - 1)) - 1;

	localparam int MAG_BITS = 11;
	localparam int TIME_BITS = 24;
	localparam int POLL_BITS = 8;
	localparam int LED_BITS = 12;

	// Working width for the ramp sum: a start or ramp magnitude on top of a clamped speed.
	localparam int ACC_BITS = ((SPEED_BITS > MAG_BITS + 1) ? SPEED_BITS : MAG_BITS + 1) + 2;

	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 24;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		CFG_LIMIT_LEVEL  = 3'd0,
		CFG_KEY_LEVEL    = 3'd1,
		CFG_IDLE_DISABLE = 3'd2,
		CFG_START_SPEED  = 3'd3,
		CFG_RAMP_STEP    = 3'd4,
		CFG_MAX_SPEED    = 3'd5,
		CFG_POLL_MOVING  = 3'd6,
		CFG_POLL_IDLE    = 3'd7
	} cfg_reg_t;

	localparam logic                 RST_LIMIT_LEVEL  = 1'b0;
	localparam logic                 RST_KEY_LEVEL    = 1'b0;
	localparam logic [TIME_BITS-1:0] RST_IDLE_DISABLE = 24'd60000;
	localparam logic [MAG_BITS-1:0]  RST_START_SPEED  = 11'd10;
	localparam logic [MAG_BITS-1:0]  RST_RAMP_STEP    = 11'd10;
	localparam logic [MAG_BITS-1:0]  RST_MAX_SPEED    = 11'd2000;
	localparam logic [POLL_BITS-1:0] RST_POLL_MOVING  = 8'd10;
	localparam logic [POLL_BITS-1:0] RST_POLL_IDLE    = 8'd110;

	// LED countdown reloads, in milliseconds less one.
	localparam logic [LED_BITS-1:0] LED_IDLE_ON  = 12'd1100;
	localparam logic [LED_BITS-1:0] LED_IDLE_OFF = 12'd2000;
	localparam logic [LED_BITS-1:0] LED_MOVE_ON  = 12'd100;
	localparam logic [LED_BITS-1:0] LED_MOVE_OFF = 12'd1000;

	typedef struct packed {
		logic limit_level;
		logic minus_key_level;
		logic plus_key_level;
	} tick_t;

	typedef struct packed {
		logic signed [SPEED_BITS-1:0] speed_command;
		logic                         drive_enable;
		logic                         moving;
		logic                         led_on;
	} result_t;

	typedef struct packed {
		logic                 limit_active_level;
		logic                 key_active_level;
		logic [TIME_BITS-1:0] idle_disable_ms;
		logic [MAG_BITS-1:0]  start_speed;
		logic [MAG_BITS-1:0]  ramp_step;
		logic [MAG_BITS-1:0]  max_speed;
		logic [POLL_BITS-1:0] poll_moving_ms;
		logic [POLL_BITS-1:0] poll_idle_ms;
	} cfg_t;

	// Zero-extends a speed magnitude into the signed working width.
	function automatic logic signed [ACC_BITS-1:0] mag_to_acc(input logic [MAG_BITS-1:0] mag);
		return $signed({{(ACC_BITS - MAG_BITS){1'b0}}, mag});
	endfunction

endpackage

/* rtl/sjsc_ifs.sv */
// ----------------------------------------------------------------------------
// Stepper jog speed controller channel interfaces
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface sjsc_tick_if import sjsc_pkg::*; ();
	logic valid;
	logic ready;
	logic limit_level;
	logic minus_key_level;
	logic plus_key_level;

	modport source (output valid, output limit_level, output minus_key_level,
		output plus_key_level, input ready);
	modport sink (input valid, input limit_level, input minus_key_level,
		input plus_key_level, output ready);
endinterface

interface sjsc_result_if import sjsc_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [SPEED_BITS-1:0] speed_command;
	logic                         drive_enable;
	logic                         moving;
	logic                         led_on;

	modport source (output valid, output speed_command, output drive_enable,
		output moving, output led_on, input ready);
	modport sink (input valid, input speed_command, input drive_enable,
		input moving, input led_on, output ready);
endinterface

interface sjsc_cfg_if import sjsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_ADDR_BITS-1:0] addr;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

/* rtl/sjsc_core.sv */
// ----------------------------------------------------------------------------
// Stepper jog speed controller core
// Per-tick state update: idle timeout, key and limit poll, status LED.
// ----------------------------------------------------------------------------
module sjsc_core import sjsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  tick_t   tick,
	input  cfg_t    cfg,
	output result_t res
);

	logic signed [SPEED_BITS-1:0] accum_q, accum_n;
	logic signed [SPEED_BITS-1:0] out_q, out_n;
	logic                         idle_q, idle_n;
	logic                         en_q, en_n;
	logic                         armed_q, armed_n;
	logic                         last_limit_q, last_limit_n;
	logic                         last_minus_q, last_minus_n;
	logic                         last_plus_q, last_plus_n;
	logic [POLL_BITS-1:0]         poll_cnt_q, poll_cnt_n;
	logic [TIME_BITS-1:0]         idle_cnt_q, idle_cnt_n;
	logic                         led_q, led_n;
	logic [LED_BITS-1:0]          led_cnt_q, led_cnt_n;

	logic signed [ACC_BITS-1:0] acc;
	logic signed [ACC_BITS-1:0] lim_mag;
	logic signed [ACC_BITS-1:0] max_acc;
	logic signed [ACC_BITS-1:0] cap_acc;
	logic                       stop;
	logic                       move;

	assign max_acc = mag_to_acc(cfg.max_speed);
	assign cap_acc = ACC_BITS'(SPEED_CAP);
	assign lim_mag = (max_acc < cap_acc) ? max_acc : cap_acc;

	always_comb begin
		accum_n      = accum_q;
		out_n        = out_q;
		idle_n       = idle_q;
		en_n         = en_q;
		armed_n      = armed_q;
		last_limit_n = last_limit_q;
		last_minus_n = last_minus_q;
		last_plus_n  = last_plus_q;
		poll_cnt_n   = poll_cnt_q;
		idle_cnt_n   = idle_cnt_q;
		led_n        = led_q;
		led_cnt_n    = led_cnt_q;
		acc          = ACC_BITS'(accum_q);
		stop         = 1'b0;
		move         = 1'b0;

		// Driver disable timeout.
		if (armed_q) begin
			if (idle_cnt_q == '0) begin
				if (idle_q && en_q) begin
					en_n    = 1'b0;
					accum_n = '0;
					armed_n = 1'b0;
				end
			end else begin
				idle_cnt_n = idle_cnt_q - 1'b1;
			end
		end

		// Poll of the limit switch and the jog keys.
		if (poll_cnt_q == '0) begin
			acc = ACC_BITS'(accum_n);
			if (tick.limit_level != last_limit_q) begin
				last_limit_n = tick.limit_level;
				if (tick.limit_level == cfg.limit_active_level) begin
					stop = 1'b1;
				end
			end
			if (tick.minus_key_level != last_minus_q) begin
				last_minus_n = tick.minus_key_level;
				if (tick.minus_key_level == cfg.key_active_level) begin
					acc  = -mag_to_acc(cfg.start_speed);
					move = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end else if (tick.minus_key_level == cfg.key_active_level) begin
				acc  = acc - mag_to_acc(cfg.ramp_step);
				move = 1'b1;
			end
			if (tick.plus_key_level != last_plus_q) begin
				last_plus_n = tick.plus_key_level;
				if (tick.plus_key_level == cfg.key_active_level) begin
					acc  = mag_to_acc(cfg.start_speed);
					move = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end else if (tick.plus_key_level == cfg.key_active_level) begin
				acc  = acc + mag_to_acc(cfg.ramp_step);
				move = 1'b1;
			end
			if (acc > lim_mag) begin
				acc = lim_mag;
			end
			if (acc < -lim_mag) begin
				acc = -lim_mag;
			end
			accum_n = acc[SPEED_BITS-1:0];

			if (stop) begin
				if (!idle_q) begin
					out_n      = '0;
					idle_n     = 1'b1;
					idle_cnt_n = cfg.idle_disable_ms;
					armed_n    = 1'b1;
					accum_n    = '0;
				end
			end else if (move) begin
				if (out_q != accum_n) begin
					out_n   = accum_n;
					idle_n  = 1'b0;
					en_n    = 1'b1;
					armed_n = 1'b0;
				end
			end
			poll_cnt_n = idle_n ? cfg.poll_idle_ms : cfg.poll_moving_ms;
		end else begin
			poll_cnt_n = poll_cnt_q - 1'b1;
		end

		// Status LED blink, timing chosen from the new LED and idle state.
		if (led_cnt_q == '0) begin
			led_n = !led_q;
			if (idle_n) begin
				led_cnt_n = led_n ? LED_IDLE_ON : LED_IDLE_OFF;
			end else begin
				led_cnt_n = led_n ? LED_MOVE_ON : LED_MOVE_OFF;
			end
		end else begin
			led_cnt_n = led_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q      <= '0;
			out_q        <= '0;
			idle_q       <= 1'b1;
			en_q         <= 1'b1;
			armed_q      <= 1'b1;
			last_limit_q <= ~RST_LIMIT_LEVEL;
			last_minus_q <= ~RST_KEY_LEVEL;
			last_plus_q  <= ~RST_KEY_LEVEL;
			poll_cnt_q   <= '0;
			idle_cnt_q   <= RST_IDLE_DISABLE;
			led_q        <= 1'b0;
			led_cnt_q    <= '0;
		end else if (step) begin
			accum_q      <= accum_n;
			out_q        <= out_n;
			idle_q       <= idle_n;
			en_q         <= en_n;
			armed_q      <= armed_n;
			last_limit_q <= last_limit_n;
			last_minus_q <= last_minus_n;
			last_plus_q  <= last_plus_n;
			poll_cnt_q   <= poll_cnt_n;
			idle_cnt_q   <= idle_cnt_n;
			led_q        <= led_n;
			led_cnt_q    <= led_cnt_n;
		end
	end

	assign res.speed_command = out_n;
	assign res.drive_enable  = en_n;
	assign res.moving        = !idle_n;
	assign res.led_on        = led_n;

endmodule

/* rtl/sjsc_obuf.sv */
// ----------------------------------------------------------------------------
// Stepper jog speed controller result buffer
// Two-entry output register with skid slot in front of the result channel.
// ----------------------------------------------------------------------------
module sjsc_obuf import sjsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    room,
	sjsc_result_if.source result
);

	logic    main_v_q;
	logic    skid_v_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop  = main_v_q && result.ready;
	assign room = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
				if (push) begin
					skid_q <= push_data;
				end
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign result.valid         = main_v_q;
	assign result.speed_command = main_q.speed_command;
	assign result.drive_enable  = main_q.drive_enable;
	assign result.moving        = main_q.moving;
	assign result.led_on        = main_q.led_on;

endmodule

/* rtl/stepper_jog_speed_controller_unit.sv */
// ----------------------------------------------------------------------------
// Stepper jog speed controller
// Millisecond-tick jog controller: polls the limit switch and two jog keys,
// ramps a signed speed command, times out the driver and blinks a status LED.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                          Transfer
//  --------  ---------  -----------------------------------------------  -------------
//  tick      in         limit_level, minus_key_level, plus_key_level     valid & ready
//  result    out        speed_command, drive_enable, moving, led_on      valid & ready
//  cfg       in         addr (register number), data                     valid & ready
//
// Each tick transfer lands in an input register; once the result buffer has
// room the tick is applied to the controller state and its result is written
// into the output register, so one tick is taken every clock cycle while the
// result buffer has room, and a result is offered from the output register
// once its tick has passed through the input register.
// Reset is asynchronous and active low; it restores every valid flag and state
// register to its documented power-up value, so no clearing pass is needed.
// A stalled result channel is absorbed by a skid slot behind the output
// register; ticks stop being taken only once the output register, the skid
// slot and the input register all hold an item.
// Configuration writes are taken on every cycle and land in registers.
// ----------------------------------------------------------------------------
module stepper_jog_speed_controller_unit import sjsc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	sjsc_tick_if.sink      tick,
	sjsc_result_if.source  result,
	sjsc_cfg_if.sink       cfg
);

	// Configuration registers.
	cfg_t cfg_q;

	// Input stage.
	logic  valid_s1;
	tick_t tick_s1;

	// Hand-off between the input stage and the result buffer.
	logic    room;
	logic    advance;
	result_t res;

	// The configuration port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit_active_level <= RST_LIMIT_LEVEL;
			cfg_q.key_active_level   <= RST_KEY_LEVEL;
			cfg_q.idle_disable_ms    <= RST_IDLE_DISABLE;
			cfg_q.start_speed        <= RST_START_SPEED;
			cfg_q.ramp_step          <= RST_RAMP_STEP;
			cfg_q.max_speed          <= RST_MAX_SPEED;
			cfg_q.poll_moving_ms     <= RST_POLL_MOVING;
			cfg_q.poll_idle_ms       <= RST_POLL_IDLE;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.addr))
				CFG_LIMIT_LEVEL:  cfg_q.limit_active_level <= cfg.data[0];
				CFG_KEY_LEVEL:    cfg_q.key_active_level   <= cfg.data[0];
				CFG_IDLE_DISABLE: cfg_q.idle_disable_ms    <= cfg.data[TIME_BITS-1:0];
				CFG_START_SPEED:  cfg_q.start_speed        <= cfg.data[MAG_BITS-1:0];
				CFG_RAMP_STEP:    cfg_q.ramp_step          <= cfg.data[MAG_BITS-1:0];
				CFG_MAX_SPEED:    cfg_q.max_speed          <= cfg.data[MAG_BITS-1:0];
				CFG_POLL_MOVING:  cfg_q.poll_moving_ms     <= cfg.data[POLL_BITS-1:0];
				CFG_POLL_IDLE:    cfg_q.poll_idle_ms       <= cfg.data[POLL_BITS-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// The held tick moves on whenever the result buffer has a free slot, and
	// the input register refills in the same cycle.
	assign advance    = valid_s1 && room;
	assign tick.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.valid && tick.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.limit_level     <= tick.limit_level;
			tick_s1.minus_key_level <= tick.minus_key_level;
			tick_s1.plus_key_level  <= tick.plus_key_level;
		end
	end

	// Controller state: advances by exactly one tick per hand-off.
	sjsc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (tick_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// Output register with its skid slot.
	sjsc_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (res),
		.room      (room),
		.result    (result)
	);

endmodule
